// ----- sv/bmprle_pkg.sv -----
package bmprle_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [12:0] WIDTH_RESET  = 13'd4096;
  localparam logic [12:0] HEIGHT_RESET = 13'd4096;

  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  localparam logic [2:0] EV_RUN   = 3'd0;
  localparam logic [2:0] EV_LINE  = 3'd1;
  localparam logic [2:0] EV_DONE  = 3'd2;
  localparam logic [2:0] EV_TRUNC = 3'd3;
  localparam logic [2:0] EV_OOB   = 3'd4;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_RUN   = 3'd1;
  localparam logic [2:0] OP_EOL   = 3'd2;
  localparam logic [2:0] OP_DELTA = 3'd3;
  localparam logic [2:0] OP_DONE  = 3'd4;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [11:0] start_x;
    logic [11:0] row_y;
    logic [7:0]  run_length;
    logic [7:0]  index_even;
    logic [7:0]  index_odd;
  } out_item_t;

  typedef struct packed {
    logic [2:0] code;
    logic       trunc;
    logic [7:0] len;
    logic [7:0] ev;
    logic [7:0] od;
    logic [7:0] dx;
    logic [7:0] dy;
  } op_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic [12:0] image_width;
    logic [12:0] image_height;
  } geom_t;

  typedef struct packed {
    logic        load;
    logic [12:0] value;
  } height_wr_t;

endpackage

// ----- sv/bmp_rle_decoder.sv -----
// bmp rle8 / rle4 stream parser
// in channel: one compressed byte per transfer, with stream_end on the last
// byte; in_ready drops only while the four-entry op queue is full
// out channel: one event per transfer (pixel run, line done, image done,
// truncated stream, out of bounds); bytes that only set up parse state give
// no event
// cfg channel: always ready; index 0 nibble_mode, 1 image_width,
// 2 image_height (also reloads the row cursor); write only while idle
// latency: out_valid rises one cycle after its byte's transfer, so the event
// transfer comes at the earliest two clock edges after the byte's
// throughput: one byte per cycle, set by the single parse step in the front
// and the single cursor update in the back
// reset: parser expects a count byte, cursor at column 0 of the top row,
// registers back to 8-bit mode and 4096 by 4096
// receiver stall: the output register holds the event and the queue absorbs
// up to four more ops before in_ready drops
// after image done or an error all bytes are taken and dropped until reset
module bmp_rle_decoder
  import bmprle_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic       nibble_mode;
  geom_t      geom;
  height_wr_t height_wr;
  q_status_t  q_stat;
  logic       accept, push, pop;
  op_t        push_op, pop_op;
  logic       cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid && cfg_ready;
  assign in_ready = !q_stat.full;
  assign accept = in_valid && in_ready;
  assign height_wr.load = cfg_wr && (cfg_index == CFG_HEIGHT);
  assign height_wr.value = cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      nibble_mode <= 1'b0;
      geom.image_width <= WIDTH_RESET;
      geom.image_height <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_NIBBLE: nibble_mode <= cfg_data[0];
        CFG_WIDTH:  geom.image_width <= cfg_data;
        CFG_HEIGHT: geom.image_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bmprle_front u_front (
    .clk         (clk),
    .rst         (rst),
    .nibble_mode (nibble_mode),
    .accept      (accept),
    .item        (in_data),
    .push        (push),
    .op          (push_op)
  );

  bmprle_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (pop_op),
    .stat    (q_stat)
  );

  bmprle_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .height_wr (height_wr),
    .q_stat    (q_stat),
    .op        (pop_op),
    .pop       (pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_run_not_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_kind == EV_RUN |-> out_data.run_length != 8'd0)
    else $error("empty pixel run");

  a_other_no_run_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_kind != EV_RUN |->
      out_data.run_length == 8'd0 && out_data.start_x == 12'd0)
    else $error("run fields set on a non-run event");

  a_byte_mode_same_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_kind == EV_RUN && !nibble_mode |->
      out_data.index_even == out_data.index_odd)
    else $error("index mismatch in 8-bit mode");

endmodule

// ----- sv/bmprle_front.sv -----
module bmprle_front
  import bmprle_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     nibble_mode,
  input  logic     accept,
  input  in_item_t item,
  output logic     push,
  output op_t      op
);

  localparam logic [2:0] PH_COUNT  = 3'd0;
  localparam logic [2:0] PH_RUNVAL = 3'd1;
  localparam logic [2:0] PH_ESC    = 3'd2;
  localparam logic [2:0] PH_LIT    = 3'd3;
  localparam logic [2:0] PH_PAD    = 3'd4;
  localparam logic [2:0] PH_DX     = 3'd5;
  localparam logic [2:0] PH_DY     = 3'd6;
  localparam logic [2:0] PH_HALT   = 3'd7;

  logic [2:0] phase, phase_next;
  logic [7:0] pending_count, pending_count_next;
  logic [7:0] literals_left, literals_left_next;
  logic       pad_pending, pad_pending_next;
  logic [7:0] delta_dx, delta_dx_next;
  logic [7:0] b;
  logic [7:0] lit_len;
  logic [8:0] nb_sum;

  always_comb begin
    b = item.stream_byte;
    phase_next = phase;
    pending_count_next = pending_count;
    literals_left_next = literals_left;
    pad_pending_next = pad_pending;
    delta_dx_next = delta_dx;
    nb_sum = {1'b0, b} + 9'd1;
    lit_len = (nibble_mode && literals_left >= 8'd2) ? 8'd2 : 8'd1;
    op = '0;
    op.code = OP_NONE;
    op.trunc = item.stream_end;
    op.ev = nibble_mode ? {4'b0, b[7:4]} : b;
    op.od = nibble_mode ? {4'b0, b[3:0] & NIBBLE_MASK} : b;
    op.dx = delta_dx;
    op.dy = b;
    case (phase)
      PH_COUNT: begin
        if (b == 8'd0) begin
          phase_next = PH_ESC;
        end else begin
          pending_count_next = b;
          phase_next = PH_RUNVAL;
        end
      end
      PH_RUNVAL: begin
        op.code = OP_RUN;
        op.len = pending_count;
        phase_next = PH_COUNT;
      end
      PH_ESC: begin
        if (b == 8'd0) begin
          op.code = OP_EOL;
          phase_next = PH_COUNT;
        end else if (b == 8'd1) begin
          op.code = OP_DONE;
          op.trunc = 1'b0;
          phase_next = PH_HALT;
        end else if (b == 8'd2) begin
          phase_next = PH_DX;
        end else begin
          literals_left_next = b;
          pad_pending_next = nibble_mode ? nb_sum[1] : b[0];
          phase_next = PH_LIT;
        end
      end
      PH_LIT: begin
        op.code = OP_RUN;
        op.len = lit_len;
        literals_left_next = (literals_left > lit_len) ? literals_left - lit_len : 8'd0;
        if (literals_left_next == 8'd0) begin
          phase_next = pad_pending ? PH_PAD : PH_COUNT;
        end
      end
      PH_PAD: begin
        phase_next = PH_COUNT;
      end
      PH_DX: begin
        delta_dx_next = b;
        phase_next = PH_DY;
      end
      PH_DY: begin
        op.code = OP_DELTA;
        phase_next = PH_COUNT;
      end
      default: begin
        op.trunc = 1'b0;
      end
    endcase
    if (item.stream_end && phase_next != PH_HALT) begin
      phase_next = PH_HALT;
    end
    push = accept && (phase != PH_HALT) && ((op.code != OP_NONE) || op.trunc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_COUNT;
      pending_count <= '0;
      literals_left <= '0;
      pad_pending <= 1'b0;
      delta_dx <= '0;
    end else if (accept && phase != PH_HALT) begin
      phase <= phase_next;
      pending_count <= pending_count_next;
      literals_left <= literals_left_next;
      pad_pending <= pad_pending_next;
      delta_dx <= delta_dx_next;
    end
  end

endmodule

// ----- sv/bmprle_queue.sv -----
module bmprle_queue
  import bmprle_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  op_t       push_op,
  input  logic      pop,
  output op_t       pop_op,
  output q_status_t stat
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  op_t             entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  assign stat.empty = (count == '0);
  assign stat.full = (count == CNTW'(QUEUE_DEPTH));
  assign pop_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

// ----- sv/bmprle_back.sv -----
module bmprle_back
  import bmprle_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic       clk,
  input  logic       rst,
  input  geom_t      geom,
  input  height_wr_t height_wr,
  input  q_status_t  q_stat,
  input  op_t        op,
  output logic       pop,
  input  logic       out_ready,
  output logic       out_valid,
  output out_item_t  out_data
);

  localparam int CW = $clog2(2 * MAX_DIM);
  localparam int SW = (CW + 1 > 14) ? CW + 1 : 14;
  localparam logic [SW-1:0] CUR_MAX = SW'(2 * MAX_DIM - 1);
  localparam logic [SW-1:0] LIM = SW'(MAX_DIM);

  logic [CW-1:0] cursor_x, cursor_x_next;
  logic [CW-1:0] cursor_y, cursor_y_next;
  logic          halted, halted_next;
  logic [SW-1:0] xw, yw, wc, hc, sum_x, sum_d, y_eol, y_dy, sat_x, sat_d;
  logic          row_ok, err, emit;
  out_item_t     res;

  function automatic logic [SW-1:0] clamp_dim(input logic [12:0] v);
    logic [SW-1:0] w;
    w = SW'(v);
    return (w > LIM) ? LIM : w;
  endfunction

  function automatic logic [CW-1:0] top_row(input logic [12:0] h);
    logic [SW-1:0] c;
    logic [SW-1:0] t;
    c = clamp_dim(h);
    t = (c == '0) ? CUR_MAX : c - SW'(1);
    return t[CW-1:0];
  endfunction

  assign pop = !q_stat.empty && (!out_valid || out_ready);

  always_comb begin
    xw = SW'(cursor_x);
    yw = SW'(cursor_y);
    wc = clamp_dim(geom.image_width);
    hc = clamp_dim(geom.image_height);
    row_ok = (yw < hc);
    sum_x = xw + SW'(op.len);
    sum_d = xw + SW'(op.dx);
    sat_x = (sum_x > CUR_MAX) ? CUR_MAX : sum_x;
    sat_d = (sum_d > CUR_MAX) ? CUR_MAX : sum_d;
    y_eol = (yw == '0) ? CUR_MAX : yw - SW'(1);
    y_dy = (yw == CUR_MAX || SW'(op.dy) > yw) ? CUR_MAX : yw - SW'(op.dy);
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    halted_next = halted;
    err = 1'b0;
    emit = 1'b0;
    res = '0;
    case (op.code)
      OP_RUN: begin
        if (!row_ok || sum_x > wc) begin
          err = 1'b1;
        end else begin
          emit = 1'b1;
          res.event_kind = EV_RUN;
          res.start_x = xw[11:0];
          res.row_y = yw[11:0];
          res.run_length = op.len;
          res.index_even = op.ev;
          res.index_odd = op.od;
          cursor_x_next = sat_x[CW-1:0];
        end
      end
      OP_EOL: begin
        if (!row_ok) begin
          err = 1'b1;
        end else begin
          emit = 1'b1;
          res.event_kind = EV_LINE;
          res.row_y = yw[11:0];
          cursor_x_next = '0;
          cursor_y_next = y_eol[CW-1:0];
        end
      end
      OP_DELTA: begin
        if (!row_ok) begin
          err = 1'b1;
        end else begin
          emit = 1'b1;
          res.event_kind = EV_LINE;
          res.row_y = yw[11:0];
          cursor_x_next = sat_d[CW-1:0];
          cursor_y_next = y_dy[CW-1:0];
        end
      end
      OP_DONE: begin
        emit = 1'b1;
        res.event_kind = EV_DONE;
        halted_next = 1'b1;
      end
      default: begin
      end
    endcase
    if (err) begin
      emit = 1'b1;
      res = '0;
      res.event_kind = EV_OOB;
      halted_next = 1'b1;
    end else if (op.trunc) begin
      emit = 1'b1;
      res = '0;
      res.event_kind = EV_TRUNC;
      halted_next = 1'b1;
    end
    if (halted) begin
      emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= top_row(HEIGHT_RESET);
      halted <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (height_wr.load) begin
        cursor_y <= top_row(height_wr.value);
      end else if (pop && !halted) begin
        cursor_x <= cursor_x_next;
        cursor_y <= cursor_y_next;
        halted <= halted_next;
      end
      if (!out_valid || out_ready) begin
        out_valid <= pop && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_data <= res;
    end
  end

endmodule
